FILE: rtl/palette_indexer_nibble_packer_defines.svh
// assertion macros shared by the palette indexer rtl
// no dependencies; the including module must have clk and rst_n in scope
`ifndef PALETTE_INDEXER_NIBBLE_PACKER_DEFINES_SVH
`define PALETTE_INDEXER_NIBBLE_PACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PIN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PIN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pin_pkg.sv
// shared types and constants for the palette indexer / nibble packer
// no dependencies
package pin_pkg;

    localparam int NIB_W   = 4;
    localparam int CNT_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 24;

    // result kind codes
    localparam logic [1:0] KIND_INDEX   = 2'd0;
    localparam logic [1:0] KIND_COUNT   = 2'd1;
    localparam logic [1:0] KIND_PALETTE = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              image_end;
    } pixel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [1:0]        kind;
        logic              end_of_run;
    } result_t;

    typedef enum logic {
        CMD_EMIT,
        CMD_DUMP
    } cmd_op_t;

    // emit: one result as given; dump: data byte, then count and palette
    typedef struct packed {
        cmd_op_t           op;
        logic [BYTE_W-1:0] data;
        logic [1:0]        kind;
        logic              end_of_run;
        logic [CNT_W-1:0]  count;
    } cmd_t;

endpackage

FILE: rtl/pin_cmd_fifo.sv
// two-entry command queue between front and back end
// depends on pin_pkg
module pin_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pin_pkg::cmd_t push_cmd,
    input  logic          pop,
    output pin_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    pin_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/pin_front.sv
// front end: palette match, append, nibble pairing, command issue
// depends on pin_pkg
module pin_front #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pin_pkg::pixel_t                   pixel,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    output logic                              cmd_push,
    output pin_pkg::cmd_t                     cmd,
    input  logic                              queue_full,
    input  logic                              dump_done,
    input  logic [$clog2(PALETTE_DEPTH)-1:0]  rd_idx,
    output logic [pin_pkg::COLOR_W-1:0]       rd_color
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    logic [pin_pkg::COLOR_W-1:0] table_reg [PALETTE_DEPTH];
    logic [pin_pkg::CNT_W-1:0]   count_reg,    count_next;
    logic [pin_pkg::NIB_W-1:0]   held_reg,     held_next;
    logic                        pending_reg,  pending_next;
    logic                        overflow_reg, overflow_next;
    logic                        wait_reg,     wait_next;

    logic [pin_pkg::COLOR_W-1:0] color;
    logic                        accept;
    logic                        hit;
    logic [pin_pkg::NIB_W-1:0]   hit_idx;
    logic [pin_pkg::NIB_W-1:0]   idx;
    logic                        table_full;
    logic                        wr_en;
    logic [pin_pkg::CNT_W-1:0]   count_after;

    assign color       = {pixel.red, pixel.green, pixel.blue};
    assign pixel_ready = !queue_full && !wait_reg;
    assign accept      = pixel_valid && pixel_ready;
    assign rd_color    = table_reg[rd_idx];
    assign table_full  = (count_reg == pin_pkg::CNT_W'(PALETTE_DEPTH));

    // parallel compare, lowest matching entry wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = PALETTE_DEPTH - 1; i >= 0; i--)
        begin
            if ((pin_pkg::CNT_W'(i) < count_reg) && (table_reg[i] == color))
            begin
                hit     = 1'b1;
                hit_idx = pin_pkg::NIB_W'(i);
            end
        end
    end

    assign idx         = hit ? hit_idx : count_reg[pin_pkg::NIB_W-1:0];
    assign count_after = hit ? count_reg : count_reg + pin_pkg::CNT_W'(1);

    always_comb
    begin
        count_next    = count_reg;
        held_next     = held_reg;
        pending_next  = pending_reg;
        overflow_next = overflow_reg;
        wait_next     = wait_reg;
        wr_en         = 1'b0;
        cmd_push      = 1'b0;
        cmd           = '0;
        cmd.op        = pin_pkg::CMD_EMIT;

        if (dump_done)
        begin
            wait_next = 1'b0;
        end

        if (accept)
        begin
            if (overflow_reg)
            begin
                // dropping pixels until the image ends
                if (pixel.image_end)
                begin
                    overflow_next = 1'b0;
                    count_next    = '0;
                    held_next     = '0;
                    pending_next  = 1'b0;
                end
            end
            else if (!hit && table_full)
            begin
                cmd_push       = 1'b1;
                cmd.kind       = pin_pkg::KIND_ERROR;
                cmd.end_of_run = 1'b1;
                if (pixel.image_end)
                begin
                    count_next   = '0;
                    held_next    = '0;
                    pending_next = 1'b0;
                end
                else
                begin
                    overflow_next = 1'b1;
                end
            end
            else
            begin
                wr_en      = !hit;
                count_next = count_after;
                if (pixel.image_end)
                begin
                    // pair byte or flushed odd nibble, then the trailer
                    cmd_push     = 1'b1;
                    cmd.op       = pin_pkg::CMD_DUMP;
                    cmd.kind     = pin_pkg::KIND_INDEX;
                    cmd.data     = pending_reg ? {held_reg, idx}
                                               : {idx, pin_pkg::NIB_W'(0)};
                    cmd.count    = count_after;
                    count_next   = '0;
                    held_next    = '0;
                    pending_next = 1'b0;
                    wait_next    = 1'b1;
                end
                else if (pending_reg)
                begin
                    cmd_push       = 1'b1;
                    cmd.kind       = pin_pkg::KIND_INDEX;
                    cmd.data       = {held_reg, idx};
                    cmd.end_of_run = 1'b1;
                    held_next      = '0;
                    pending_next   = 1'b0;
                end
                else
                begin
                    held_next    = idx;
                    pending_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            held_reg     <= '0;
            pending_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            wait_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            held_reg     <= held_next;
            pending_reg  <= pending_next;
            overflow_reg <= overflow_next;
            wait_reg     <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_reg[count_reg[IDX_W-1:0]] <= color;
        end
    end

endmodule

FILE: rtl/pin_back.sv
// back end: executes queued commands and sequences the palette trailer
// depends on pin_pkg
module pin_back #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pin_pkg::cmd_t                     cmd,
    input  logic                              queue_empty,
    output logic                              cmd_pop,
    output logic [$clog2(PALETTE_DEPTH)-1:0]  rd_idx,
    input  logic [pin_pkg::COLOR_W-1:0]       rd_color,
    output logic                              dump_done,
    output pin_pkg::result_t                  result,
    output logic                              result_valid,
    input  logic                              result_ready
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_PAL
    } state_t;

    state_t                    state_reg,  state_next;
    logic [pin_pkg::CNT_W-1:0] cnt_reg,    cnt_next;
    logic [IDX_W-1:0]          entry_reg,  entry_next;
    logic [1:0]                comp_reg,   comp_next;
    pin_pkg::result_t          result_reg, result_next;
    logic                      valid_reg,  valid_next;

    logic                      advance;
    logic                      last_byte;
    logic [pin_pkg::BYTE_W-1:0] comp_byte;

    assign advance      = !valid_reg || result_ready;
    assign rd_idx       = entry_reg;
    assign result       = result_reg;
    assign result_valid = valid_reg;
    assign last_byte    = (comp_reg == 2'd2)
                       && (pin_pkg::CNT_W'(entry_reg) == cnt_reg - pin_pkg::CNT_W'(1));

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    comp_byte = rd_color[23:16];
            2'd1:    comp_byte = rd_color[15:8];
            default: comp_byte = rd_color[7:0];
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        entry_next  = entry_reg;
        comp_next   = comp_reg;
        result_next = result_reg;
        valid_next  = valid_reg && !result_ready;
        cmd_pop     = 1'b0;
        dump_done   = 1'b0;

        if (advance)
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        cmd_pop                = 1'b1;
                        valid_next             = 1'b1;
                        result_next.out_byte   = cmd.data;
                        result_next.kind       = cmd.kind;
                        result_next.end_of_run = cmd.end_of_run;
                        if (cmd.op == pin_pkg::CMD_DUMP)
                        begin
                            state_next = S_COUNT;
                            cnt_next   = cmd.count;
                        end
                    end
                end
                S_COUNT:
                begin
                    valid_next             = 1'b1;
                    result_next.out_byte   = pin_pkg::BYTE_W'(cnt_reg);
                    result_next.kind       = pin_pkg::KIND_COUNT;
                    result_next.end_of_run = 1'b0;
                    entry_next             = '0;
                    comp_next              = 2'd0;
                    state_next             = S_PAL;
                end
                S_PAL:
                begin
                    valid_next             = 1'b1;
                    result_next.out_byte   = comp_byte;
                    result_next.kind       = pin_pkg::KIND_PALETTE;
                    result_next.end_of_run = last_byte;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        entry_next = entry_reg + IDX_W'(1);
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                    end
                    if (last_byte)
                    begin
                        dump_done  = 1'b1;
                        entry_next = '0;
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            entry_reg  <= '0;
            comp_reg   <= 2'd0;
            result_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            entry_reg  <= entry_next;
            comp_reg   <= comp_next;
            result_reg <= result_next;
            valid_reg  <= valid_next;
        end
    end

endmodule

FILE: rtl/palette_indexer_nibble_packer.sv
// top level of the 4-bit palette indexer and nibble packer
// depends on pin_pkg, pin_front, pin_cmd_fifo, pin_back and the defines header

// Takes one RGB pixel per transaction in raster order and returns a stream of
// byte transactions: packed 4-bit palette indices (first pixel in the high
// nibble), and on the pixel flagged image_end the last index byte (an odd
// nibble flushed in the high half), a color count byte and red, green, blue for
// every palette entry; the palette is then empty for the next image. A color
// beyond PALETTE_DEPTH gives a single error transaction, after which pixels are
// dropped up to and including the end of the image. A pixel is taken every
// cycle as long as the two-entry command queue has room; an emit command gives
// one result byte, while the dump command of the last pixel of an image makes
// the back end emit the index byte, a count byte and three bytes per palette
// entry, and no new pixel is taken until the last palette byte has been loaded
// into the output register, because the trailer is read out of the same palette
// registers that the next image would overwrite. Result channel stalls hold the
// back end and back up through the queue to pixel_ready.
`include "palette_indexer_nibble_packer_defines.svh"

module palette_indexer_nibble_packer #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pin_pkg::pixel_t  pixel,
    input  logic             pixel_valid,
    output logic             pixel_ready,
    output pin_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_ready
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    // front end to queue
    pin_pkg::cmd_t cmd_in;
    logic          cmd_push;
    logic          queue_full;

    // queue to back end
    pin_pkg::cmd_t cmd_head;
    logic          cmd_pop;
    logic          queue_empty;

    // palette readout for the trailer, and its completion
    logic [IDX_W-1:0]            rd_idx;
    logic [pin_pkg::COLOR_W-1:0] rd_color;
    logic                        dump_done;

    pin_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in),
        .queue_full  (queue_full),
        .dump_done   (dump_done),
        .rd_idx      (rd_idx),
        .rd_color    (rd_color)
    );

    pin_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_in),
        .pop      (cmd_pop),
        .head     (cmd_head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    pin_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_head),
        .queue_empty  (queue_empty),
        .cmd_pop      (cmd_pop),
        .rd_idx       (rd_idx),
        .rd_color     (rd_color),
        .dump_done    (dump_done),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // queue must never overflow or underflow
    `PIN_ASSERT_IMPL(a_push_not_full, cmd_push, !queue_full, "command pushed into full queue")
    `PIN_ASSERT_IMPL(a_pop_not_empty, cmd_pop, !queue_empty, "command popped from empty queue")
    // a trailer always covers at least the color of the last pixel
    `PIN_ASSERT_IMPL(a_dump_count, cmd_push && (cmd_in.op == pin_pkg::CMD_DUMP),
                     (cmd_in.count != '0) && (cmd_in.end_of_run == 1'b0),
                     "trailer command with empty palette")
    // front end holds off pixels while a trailer is being read out
    `PIN_ASSERT_NEXT(a_dump_blocks, cmd_push && (cmd_in.op == pin_pkg::CMD_DUMP),
                     !pixel_ready, "pixel accepted during palette readout")

endmodule

FILE: test/palette_stream_checker.sv
// watches the pixel and result channels of the palette indexer, predicts the byte stream
// depends on pin_pkg for the transaction types and kind codes
`timescale 1ns / 1ps

module palette_stream_checker #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pin_pkg::pixel_t  pixel,
    input  logic             pixel_valid,
    input  logic             pixel_ready,
    input  pin_pkg::result_t result,
    input  logic             result_valid,
    input  logic             result_ready,
    output int               mismatches,
    output int               outstanding
);

    // mirror of the encoder state
    logic [pin_pkg::COLOR_W-1:0] palette [16];
    logic [pin_pkg::CNT_W-1:0]   colors_used;
    logic [pin_pkg::NIB_W-1:0]   held_index;
    logic                        odd_index;
    logic                        dropping;
    int                          mismatch_count = 0;

    pin_pkg::result_t expected_bytes [$];

    assign mismatches = mismatch_count;

    function automatic void clear_image();
        colors_used = '0;
        held_index  = '0;
        odd_index   = 1'b0;
        dropping    = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input pin_pkg::result_t got,
                                   input pin_pkg::result_t want);
        $display("%0t: %s: got byte %02h kind %0d end %0b, want byte %02h kind %0d end %0b",
                 $realtime, what, got.out_byte, got.kind, got.end_of_run,
                 want.out_byte, want.kind, want.end_of_run);
        mismatch_count++;
    endtask

    // works out every byte one pixel causes and queues them in order
    task automatic encode_pixel(input pin_pkg::pixel_t p);
        logic [pin_pkg::COLOR_W-1:0] color;
        int                          slot;
        pin_pkg::result_t            step_bytes [$];
        pin_pkg::result_t            r;

        color = {p.red, p.green, p.blue};
        if (dropping)
        begin
            if (p.image_end)
                clear_image();
            return;
        end

        slot = -1;
        for (int i = 0; i < colors_used; i++)
            if (slot < 0 && palette[i] == color)
                slot = i;

        if (slot < 0)
        begin
            if (colors_used >= PALETTE_DEPTH)
            begin
                // too many colors: one error byte, then silence until the image ends
                r = '{out_byte: '0, kind: pin_pkg::KIND_ERROR, end_of_run: 1'b1};
                expected_bytes.insert(expected_bytes.size(), r);
                if (p.image_end)
                    clear_image();
                else
                    dropping = 1'b1;
                return;
            end
            slot = int'(colors_used);
            palette[slot] = color;
            colors_used++;
        end

        if (odd_index)
        begin
            r = '{out_byte: {held_index, 4'(slot)}, kind: pin_pkg::KIND_INDEX,
                  end_of_run: 1'b0};
            step_bytes.insert(step_bytes.size(), r);
            odd_index  = 1'b0;
            held_index = '0;
        end
        else
        begin
            held_index = 4'(slot);
            odd_index  = 1'b1;
        end

        if (p.image_end)
        begin
            if (odd_index)
            begin
                r = '{out_byte: {held_index, 4'h0}, kind: pin_pkg::KIND_INDEX,
                      end_of_run: 1'b0};
                step_bytes.insert(step_bytes.size(), r);
            end
            r = '{out_byte: 8'(colors_used), kind: pin_pkg::KIND_COUNT, end_of_run: 1'b0};
            step_bytes.insert(step_bytes.size(), r);
            for (int i = 0; i < colors_used; i++)
            begin
                r = '{out_byte: palette[i][23:16], kind: pin_pkg::KIND_PALETTE,
                      end_of_run: 1'b0};
                step_bytes.insert(step_bytes.size(), r);
                r = '{out_byte: palette[i][15:8], kind: pin_pkg::KIND_PALETTE,
                      end_of_run: 1'b0};
                step_bytes.insert(step_bytes.size(), r);
                r = '{out_byte: palette[i][7:0], kind: pin_pkg::KIND_PALETTE,
                      end_of_run: 1'b0};
                step_bytes.insert(step_bytes.size(), r);
            end
            clear_image();
        end

        if (step_bytes.size() > 0)
        begin
            step_bytes[step_bytes.size() - 1].end_of_run = 1'b1;
        end
        foreach (step_bytes[i])
            expected_bytes.insert(expected_bytes.size(), step_bytes[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pin_pkg::result_t want;
        if (!rst_n)
        begin
            clear_image();
            expected_bytes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
                encode_pixel(pixel);
            if (result_valid && result_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    want = '0;
                    report_mismatch("byte with nothing expected", result, want);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result.out_byte !== want.out_byte)
                        report_mismatch("out_byte differs", result, want);
                    if (result.kind !== want.kind)
                        report_mismatch("kind differs", result, want);
                    if (result.end_of_run !== want.end_of_run)
                        report_mismatch("end_of_run differs", result, want);
                end
            end
            outstanding <= expected_bytes.size();
        end
    end

endmodule

FILE: test/testbench.sv
// top of the palette indexer testbench: clock, reset, pixel stimulus and verdict
// depends on pin_pkg, the palette_indexer_nibble_packer rtl and palette_stream_checker
`timescale 1ns / 1ps

module testbench;

    localparam int PALETTE_DEPTH = 16;
    localparam int TOTAL_PIXELS  = 120;
    // watchdog limit, kept well clear of the slowest sane run
    localparam int CYCLE_LIMIT   = 300000;
    // a dump of a full palette plus queue and output register, with margin
    localparam int DRAIN_CYCLES  = 80;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    pin_pkg::pixel_t  pixel        = '0;
    logic             pixel_valid  = 1'b0;
    logic             pixel_ready;
    pin_pkg::result_t result;
    logic             result_valid;
    logic             result_ready = 1'b0;

    int mismatches;
    int outstanding;
    int cycle_count   = 0;
    int burst_left    = 0;
    int pixels_sent   = 0;
    int ready_left    = 0;
    int ready_mode    = 0;

    palette_indexer_nibble_packer #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready)
    );

    // the checker sees the same wires as the block and keeps the expected byte stream
    palette_stream_checker #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) byte_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 ns clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side back-pressure: phases of random length, each with its own
    // stall style, so stalls land on index bytes, counts and palette dumps alike
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(8, 40);
        end
        ready_left--;
        case (ready_mode)
            0: result_ready <= 1'b1;                          // no stalls at all
            1: result_ready <= 1'($urandom_range(0, 1));      // coin flip
            2: result_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
            default: result_ready <= (cycle_count % 5 != 0);  // periodic stall from the cycle counter
        endcase
    end

    // one pixel transaction; valid stays high into the next pixel unless a gap
    // starts, so back-to-back bursts never drop and raise valid in one step
    task automatic send_pixel(input logic [pin_pkg::COLOR_W-1:0] color, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        pixel_valid <= 1'b1;
        pixel       <= '{red: color[23:16], green: color[15:8], blue: color[7:0],
                         image_end: last};
        do @(posedge clk); while (!pixel_ready);
        burst_left--;
        pixels_sent++;
    endtask

    // hold the pixel side off until every predicted byte has been taken
    task automatic wait_drained();
        pixel_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // one image drawn from a set of n_colors colors; with cover_all each color
    // shows up first in order, so the palette reaches n_colors entries when there
    // are enough pixels (and overflows past PALETTE_DEPTH); raw_colors leaves every bit random
    task automatic send_image(input int n_colors, input int n_pixels,
                              input bit cover_all, input bit raw_colors);
        logic [pin_pkg::COLOR_W-1:0] color_set [$];
        logic [pin_pkg::COLOR_W-1:0] c;
        int                          pick;
        for (int i = 0; i < n_colors; i++)
        begin
            c = 24'($urandom);
            if (!raw_colors)
                c[4:0] = 5'(i);   // keeps the set distinct
            color_set.insert(color_set.size(), c);
        end
        for (int i = 0; i < n_pixels; i++)
        begin
            if (cover_all && i < n_colors)
                pick = i;
            else
                pick = $urandom_range(0, n_colors - 1);
            send_pixel(color_set[pick], i == n_pixels - 1);
        end
    endtask

    int n_colors;
    int n_pixels;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone pixel with the odd nibble flushed, extreme colors
        send_pixel(24'hFFFFFF, 1'b1);
        // two pixels, even index count, all-zero and all-one colors
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b1);
        // repeated colors hit existing entries, image ends on a match
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'hFF00FF, 1'b0);
        send_pixel(24'h00FF00, 1'b1);
        // palette overflow where the overflowing pixel is also the last one
        for (int i = 0; i < PALETTE_DEPTH + 1; i++)
            send_pixel({8'(i * 15), 8'(255 - i * 15), 8'(i)}, i == PALETTE_DEPTH);
        wait_drained();

        // a full palette dump, then an overflow in the middle of an image
        send_image(PALETTE_DEPTH, PALETTE_DEPTH + 4, 1'b1, 1'b0);
        send_image(PALETTE_DEPTH + 2, PALETTE_DEPTH + 5, 1'b1, 1'b0);

        // random images, mostly well-formed, some noise
        while (pixels_sent < TOTAL_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    n_colors = $urandom_range(1, 4);
                    n_pixels = $urandom_range(1, 10);
                    send_image(n_colors, n_pixels, 1'($urandom_range(0, 1)), 1'b0);
                end
                5, 6: send_image(PALETTE_DEPTH, $urandom_range(PALETTE_DEPTH, PALETTE_DEPTH + 6),
                                 1'b1, 1'b0);
                7:
                begin
                    n_colors = $urandom_range(5, PALETTE_DEPTH - 1);
                    send_image(n_colors, n_colors + $urandom_range(0, 6), 1'b1, 1'b0);
                end
                8:
                begin
                    n_colors = $urandom_range(PALETTE_DEPTH + 1, PALETTE_DEPTH + 3);
                    send_image(n_colors, n_colors + $urandom_range(0, 4), 1'b1, 1'b0);
                end
                default:
                begin
                    n_pixels = $urandom_range(1, 6);
                    send_image(n_pixels, n_pixels, 1'b0, 1'b1);
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        // let everything drain, then give the block time to show stray bytes
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
